FILE: src/cbo_pkg.sv
// Shared constants and helper functions for the camera basis orthonormalizer.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package cbo_pkg;

   // Default number of fraction bits of the unit vector outputs.
   localparam int OUT_FRAC_BITS_DEF = 14;

   // Width of one input component and of one output component.
   localparam int IN_W  = 24;
   localparam int OUT_W = 16;

   // Magnitudes are shrunk below 2^SHRINK_BITS before squaring.
   localparam int SHRINK_BITS = 30;

   // Register stages in front of the normalizers, and the normalizer depth
   // without its divider bits (the divider adds OUT_FRAC_BITS more).
   localparam int FRONT_STAGES     = 8;
   localparam int NORM_BASE_STAGES = 41;

   // Position of the highest set bit; zero for a zero word.
   function automatic logic [5:0] msb_pos(input logic [63:0] x);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) begin
            p = 6'(i);
         end
      end
      return p;
   endfunction

   // Smallest right shift that brings the word below 2^SHRINK_BITS.
   function automatic logic [5:0] shrink_shift(input logic [63:0] x);
      logic [5:0] p;
      p = msb_pos(x);
      return (p >= 6'(SHRINK_BITS)) ? (p - 6'(SHRINK_BITS - 1)) : 6'd0;
   endfunction

endpackage

FILE: src/cbo_norm.sv
// Pipelined 3-vector normalizer: shrink, sum of squares, square root, divide.
// Depends on cbo_pkg for the shrink limit and the bit search functions.
`timescale 1ns / 1ps

module cbo_norm import cbo_pkg::*; #(
   parameter int IW  = 24,
   parameter int OFB = OUT_FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      ce,
   input  logic [2:0][IW-1:0]        vec,
   output logic [2:0][OUT_W-1:0]     unit_vec,
   output logic                      nonzero
);

   localparam int QW      = OFB + 1;
   localparam int NW      = OFB + 32;
   localparam int LIM_INT = (OFB >= 15) ? 32767 : (1 << OFB);
   localparam logic [QW-1:0] LIM = QW'(LIM_INT);
   localparam int SQ_STEPS = 31;

   typedef struct packed {
      logic [61:0]      n;
      logic [62:0]      r;
      logic [2:0][30:0] mk;
      logic [2:0]       sg;
      logic             nz;
   } sqrt_stage_type;

   typedef struct packed {
      logic [2:0][NW-1:0] rem;
      logic [2:0][QW-1:0] q;
      logic [30:0]        root;
      logic [2:0]         sg;
      logic               nz;
   } div_stage_type;

   logic [2:0][IW-1:0]    mag_a_ff, mag_a_in, mag_b_ff;
   logic [2:0]            sg_a_ff, sg_b_ff, sg_c_ff, sg_d_ff, sg_e_ff, sg_f_ff;
   logic [5:0]            shift_b_ff, shift_b_in;
   logic [2:0][29:0]      ms_c_ff, ms_c_in, ms_d_ff, ms_e_ff, ms_f_ff;
   logic [2:0][59:0]      sq_d_ff, sq_d_in;
   logic [61:0]           sum_e_ff, sum_e_in, sum_f_ff;
   logic                  nz_e_ff, nz_e_in, nz_f_ff;
   logic [4:0]            k_f_ff, k_f_in;
   sqrt_stage_type        sqs_ff [SQ_STEPS+1];
   sqrt_stage_type        sqs_in [SQ_STEPS+1];
   div_stage_type         dvs_ff [QW+1];
   div_stage_type         dvs_in [QW+1];
   logic [2:0][OUT_W-1:0] unit_vec_ff, unit_vec_in;
   logic                  nonzero_ff;

   // Magnitudes, the common shrink shift, the shrunk magnitudes, their squares and sum, and the nonzero flag.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_a_in[i] = vec[i][IW-1] ? (~vec[i] + 1'b1) : vec[i];
         ms_c_in[i]  = 30'(mag_b_ff[i] >> shift_b_ff);
         sq_d_in[i]  = ms_c_ff[i] * ms_c_ff[i];
      end
      shift_b_in = shrink_shift(64'(mag_a_ff[0] | mag_a_ff[1] | mag_a_ff[2]));
      sum_e_in   = 62'(sq_d_ff[0]) + 62'(sq_d_ff[1]) + 62'(sq_d_ff[2]);
      nz_e_in    = |{ms_d_ff[0], ms_d_ff[1], ms_d_ff[2]};
   end

   // Even scale that lifts a nonzero sum of squares to at least 2^60.
   always_comb begin
      logic [5:0] p;
      p = msb_pos(64'(sum_e_ff));
      k_f_in = (p < 6'd60) ? 5'((6'd61 - p) >> 1) : 5'd0;
   end

   // Scale the sum and the magnitudes, then the square root digit by digit.
   always_comb begin
      logic [62:0] bit_v;
      logic [62:0] trial;
      sqs_in[0].n  = 62'(sum_f_ff << {k_f_ff, 1'b0});
      sqs_in[0].r  = '0;
      for (int i = 0; i < 3; i++) begin
         sqs_in[0].mk[i] = 31'(ms_f_ff[i]) << k_f_ff;
      end
      sqs_in[0].sg = sg_f_ff;
      sqs_in[0].nz = nz_f_ff;
      for (int g = 1; g <= SQ_STEPS; g++) begin
         bit_v     = 63'(1) << (2 * (SQ_STEPS - g));
         trial     = sqs_ff[g-1].r + bit_v;
         sqs_in[g] = sqs_ff[g-1];
         if ({1'b0, sqs_ff[g-1].n} >= trial) begin
            sqs_in[g].n = sqs_ff[g-1].n - trial[61:0];
            sqs_in[g].r = (sqs_ff[g-1].r >> 1) + bit_v;
         end else begin
            sqs_in[g].r = sqs_ff[g-1].r >> 1;
         end
      end
   end

   // Rounded quotient, one bit per stage from the top.
   always_comb begin
      logic [NW-1:0] dv;
      logic [30:0]   root;
      root = sqs_ff[SQ_STEPS].r[30:0];
      for (int i = 0; i < 3; i++) begin
         dvs_in[0].rem[i] = (NW'(sqs_ff[SQ_STEPS].mk[i]) << OFB) + NW'(root >> 1);
      end
      dvs_in[0].q    = '0;
      dvs_in[0].root = root;
      dvs_in[0].sg   = sqs_ff[SQ_STEPS].sg;
      dvs_in[0].nz   = sqs_ff[SQ_STEPS].nz;
      for (int g = 1; g <= QW; g++) begin
         dv        = NW'(dvs_ff[g-1].root) << (QW - g);
         dvs_in[g] = dvs_ff[g-1];
         for (int i = 0; i < 3; i++) begin
            if (dvs_ff[g-1].rem[i] >= dv) begin
               dvs_in[g].rem[i]       = dvs_ff[g-1].rem[i] - dv;
               dvs_in[g].q[i][QW - g] = 1'b1;
            end
         end
      end
   end

   // Clamp to the unit value and restore the sign.
   always_comb begin
      logic [QW-1:0]    qm;
      logic [OUT_W-1:0] m16;
      for (int i = 0; i < 3; i++) begin
         qm  = (dvs_ff[QW].q[i] > LIM) ? LIM : dvs_ff[QW].q[i];
         m16 = OUT_W'(qm);
         unit_vec_in[i] = dvs_ff[QW].sg[i] ? (~m16 + 1'b1) : m16;
      end
   end

   // Pipeline registers; the whole chain holds while ce is low.
   always_ff @(posedge clock) begin
      if (ce) begin
         mag_a_ff <= mag_a_in;
         for (int i = 0; i < 3; i++) begin
            sg_a_ff[i] <= vec[i][IW-1];
         end
         mag_b_ff   <= mag_a_ff;
         sg_b_ff    <= sg_a_ff;
         shift_b_ff <= shift_b_in;
         ms_c_ff    <= ms_c_in;
         sg_c_ff    <= sg_b_ff;
         sq_d_ff    <= sq_d_in;
         ms_d_ff    <= ms_c_ff;
         sg_d_ff    <= sg_c_ff;
         sum_e_ff   <= sum_e_in;
         nz_e_ff    <= nz_e_in;
         ms_e_ff    <= ms_d_ff;
         sg_e_ff    <= sg_d_ff;
         k_f_ff     <= k_f_in;
         sum_f_ff   <= sum_e_ff;
         nz_f_ff    <= nz_e_ff;
         ms_f_ff    <= ms_e_ff;
         sg_f_ff    <= sg_e_ff;
         for (int g = 0; g <= SQ_STEPS; g++) begin
            sqs_ff[g] <= sqs_in[g];
         end
         for (int g = 0; g <= QW; g++) begin
            dvs_ff[g] <= dvs_in[g];
         end
         unit_vec_ff <= unit_vec_in;
         nonzero_ff  <= dvs_ff[QW].nz;
      end
   end

   assign unit_vec = unit_vec_ff;
   assign nonzero  = nonzero_ff;

endmodule

FILE: src/camera_basis_orthonormalize.sv
// Top level of the camera basis orthonormalizer: cross products and output.
// Depends on cbo_pkg and instantiates three cbo_norm normalizers.
`timescale 1ns / 1ps

// Usage:
// A word on the req channel carries a view direction and an up hint, each
// a signed 24-bit 3-vector. The rsp channel returns one word per request:
// unit forward, right and true-up vectors in signed 16-bit fixed point with
// OUT_FRAC_BITS fraction bits, and a degenerate flag in rsp_tuser that is
// set, with all vectors zero, when the direction is zero or parallel to
// the up hint.
// The block is a single pipeline of 50 + OUT_FRAC_BITS register stages
// from acceptance to rsp_tvalid. One word is accepted every cycle while
// the output is not stalled; the depth is set by the 31-step square root
// and the one-bit-per-stage divider of the normalizers.
// When the receiver holds rsp_tready low with a word waiting, the whole
// pipeline holds and req_tready drops; words in flight are kept.
// A synchronous reset empties the pipeline; no result is shown after it
// until a new word has been accepted.
module camera_basis_orthonormalize import cbo_pkg::*; #(
   parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // dir_x, dir_y, dir_z, up_hint_x, up_hint_y, up_hint_z
   input  logic [6*IN_W-1:0]    req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // fwd_x, fwd_y, fwd_z, right_x, right_y, right_z,
   // true_up_x, true_up_y, true_up_z
   output logic [9*OUT_W-1:0]   rsp_tdata,
   // degenerate
   output logic                 rsp_tuser
);

   localparam int DEPTH = FRONT_STAGES + NORM_BASE_STAGES + OUT_FRAC_BITS + 1;
   localparam int PW    = 2 * IN_W;
   localparam int CW    = PW + 1;
   localparam int SW    = SHRINK_BITS + 1;
   localparam int TPW   = SW + IN_W;
   localparam int TW    = TPW + 1;

   logic                         ce;
   logic [DEPTH-1:0]             valid_ff, valid_in;
   logic signed [IN_W-1:0]       d_pipe_ff [FRONT_STAGES][3];
   logic signed [IN_W-1:0]       u_ff [3];
   logic signed [PW-1:0]         prod_c_ff [6], prod_c_in [6];
   logic signed [CW-1:0]         c_ff [3], c_in [3];
   logic [PW-1:0]                cm_ff [3], cm_in [3], cm4_ff [3];
   logic [2:0]                   csg_ff, csg4_ff;
   logic [5:0]                   cshift_ff, cshift_in;
   logic signed [SW-1:0]         cs_ff [3], cs_in [3], cs6_ff [3], cs7_ff [3];
   logic signed [TPW-1:0]        prod_t_ff [6], prod_t_in [6];
   logic signed [TW-1:0]         t_ff [3], t_in [3];
   logic [2:0][IN_W-1:0]         nf_vec;
   logic [2:0][SW-1:0]           nr_vec;
   logic [2:0][TW-1:0]           nt_vec;
   logic [2:0][OUT_W-1:0]        fwd_q, right_q, up_q;
   logic                         fwd_nz, right_nz, up_nz;
   logic [9*OUT_W-1:0]           rsp_data_ff, rsp_data_in;
   logic                         rsp_deg_ff, rsp_deg_in;

   // The pipeline moves whenever the output register is free or taken.
   assign ce         = !valid_ff[DEPTH-1] || rsp_tready;
   assign req_tready = ce;
   assign valid_in   = {valid_ff[DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ce) begin
         valid_ff <= valid_in;
      end
   end

   // Cross product of direction and up hint, then its magnitudes and their common shrink shift.
   always_comb begin
      prod_c_in[0] = d_pipe_ff[0][1] * u_ff[2];
      prod_c_in[1] = d_pipe_ff[0][2] * u_ff[1];
      prod_c_in[2] = d_pipe_ff[0][2] * u_ff[0];
      prod_c_in[3] = d_pipe_ff[0][0] * u_ff[2];
      prod_c_in[4] = d_pipe_ff[0][0] * u_ff[1];
      prod_c_in[5] = d_pipe_ff[0][1] * u_ff[0];
      for (int i = 0; i < 3; i++) begin
         c_in[i]  = CW'(prod_c_ff[2*i]) - CW'(prod_c_ff[2*i+1]);
         cm_in[i] = PW'(c_ff[i][CW-1] ? -c_ff[i] : c_ff[i]);
      end
      cshift_in = shrink_shift(64'(cm_ff[0] | cm_ff[1] | cm_ff[2]));
   end

   // Shrunk cross product, then its cross product with the direction.
   always_comb begin
      logic [SW-1:0] m;
      for (int i = 0; i < 3; i++) begin
         m        = {1'b0, SHRINK_BITS'(cm4_ff[i] >> cshift_ff)};
         cs_in[i] = csg4_ff[i] ? -$signed(m) : $signed(m);
      end
      prod_t_in[0] = cs_ff[1] * d_pipe_ff[5][2];
      prod_t_in[1] = cs_ff[2] * d_pipe_ff[5][1];
      prod_t_in[2] = cs_ff[2] * d_pipe_ff[5][0];
      prod_t_in[3] = cs_ff[0] * d_pipe_ff[5][2];
      prod_t_in[4] = cs_ff[0] * d_pipe_ff[5][1];
      prod_t_in[5] = cs_ff[1] * d_pipe_ff[5][0];
      for (int i = 0; i < 3; i++) begin
         t_in[i] = TW'(prod_t_ff[2*i]) - TW'(prod_t_ff[2*i+1]);
      end
   end

   // Front pipeline registers.
   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            d_pipe_ff[0][i] <= req_tdata[IN_W*i +: IN_W];
            u_ff[i]         <= req_tdata[IN_W*(3+i) +: IN_W];
            c_ff[i]         <= c_in[i];
            cm_ff[i]        <= cm_in[i];
            csg_ff[i]       <= c_ff[i][CW-1];
            cm4_ff[i]       <= cm_ff[i];
            cs_ff[i]        <= cs_in[i];
            cs6_ff[i]       <= cs_ff[i];
            cs7_ff[i]       <= cs6_ff[i];
            t_ff[i]         <= t_in[i];
         end
         for (int s = 1; s < FRONT_STAGES; s++) begin
            d_pipe_ff[s] <= d_pipe_ff[s-1];
         end
         for (int p = 0; p < 6; p++) begin
            prod_c_ff[p] <= prod_c_in[p];
            prod_t_ff[p] <= prod_t_in[p];
         end
         csg4_ff   <= csg_ff;
         cshift_ff <= cshift_in;
      end
   end

   // Three normalizers run side by side on aligned inputs.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nf_vec[i] = d_pipe_ff[FRONT_STAGES-1][i];
         nr_vec[i] = cs7_ff[i];
         nt_vec[i] = t_ff[i];
      end
   end

   cbo_norm #(.IW(IN_W), .OFB(OUT_FRAC_BITS)) u_norm_fwd (
      .clock    (clock),
      .ce       (ce),
      .vec      (nf_vec),
      .unit_vec (fwd_q),
      .nonzero  (fwd_nz)
   );

   cbo_norm #(.IW(SW), .OFB(OUT_FRAC_BITS)) u_norm_right (
      .clock    (clock),
      .ce       (ce),
      .vec      (nr_vec),
      .unit_vec (right_q),
      .nonzero  (right_nz)
   );

   cbo_norm #(.IW(TW), .OFB(OUT_FRAC_BITS)) u_norm_up (
      .clock    (clock),
      .ce       (ce),
      .vec      (nt_vec),
      .unit_vec (up_q),
      .nonzero  (up_nz)
   );

   // Output word: all vectors are zeroed when any of them vanished.
   always_comb begin
      rsp_deg_in  = !(fwd_nz && right_nz && up_nz);
      rsp_data_in = rsp_deg_in ? '0 : {up_q, right_q, fwd_q};
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rsp_data_ff <= rsp_data_in;
         rsp_deg_ff  <= rsp_deg_in;
      end
   end

   assign rsp_tvalid = valid_ff[DEPTH-1];
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_deg_ff;

endmodule

FILE: src/cbo_checker.sv
// Port-level assertions for the camera basis orthonormalizer, and their bind.
// Depends on cbo_pkg for the field widths; binds to camera_basis_orthonormalize.
`timescale 1ns / 1ps

module cbo_checker import cbo_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [9*OUT_W-1:0] rsp_tdata,
   input logic               rsp_tuser
);

   // Input side is ready exactly when the output word can move.
   a_ready_follows_out: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not track the output register");

   // A degenerate word carries only zero vectors.
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("degenerate word with nonzero vectors");

   // A good word has a nonzero forward vector.
   a_forward_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[3*OUT_W-1:0] != '0)
      else $error("forward vector is zero in a good word");

   // A stalled word stays put.
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser))
      else $error("stalled output word changed");

endmodule

bind camera_basis_orthonormalize cbo_checker u_cbo_checker (.*);
